>>> rtl/psamp_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and types for the partial shuffle sampler.
package psamp_pkg;

   // Payload widths
   localparam int DATA_W     = 8;
   localparam int BOUND_W    = 8;
   localparam int COUNT_W    = 9;
   localparam int RANDOM_W   = 31;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   // Parameter defaults
   localparam int DEFAULT_POOL_DEPTH  = 256;
   localparam int DEFAULT_RANDOM_BITS = 31;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_BOUND      = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXTRACTION_COUNT = 1'b1;

   localparam logic [BOUND_W-1:0] UPPER_BOUND_RESET      = 8'd255;
   localparam logic [COUNT_W-1:0] EXTRACTION_COUNT_RESET = 9'd256;

   // Action codes
   localparam logic ACT_START   = 1'b0;
   localparam logic ACT_EXTRACT = 1'b1;

   // Pool control from pipeline stage 3
   typedef struct packed {
      logic rd_en;   // capture read data for the entry moving into stage 3
      logic clear;   // open a new draw: every entry holds its own index again
      logic wr_en;   // move the top entry into the drawn slot
   } pool_ctl_type;

endpackage

>>> rtl/psamp_req_if.sv
`timescale 1ns / 1ps
// Request channel: action and random word with valid/ready.
interface psamp_req_if import psamp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                action;
   logic [RANDOM_W-1:0] random_word;

   modport source (output valid, action, random_word, input ready);
   modport sink   (input valid, action, random_word, output ready);
endinterface

>>> rtl/psamp_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: drawn value, error and last flags with valid/ready.
interface psamp_rsp_if import psamp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] drawn_value;
   logic              error;
   logic              last;

   modport source (output valid, drawn_value, error, last, input ready);
   modport sink   (input valid, drawn_value, error, last, output ready);
endinterface

>>> rtl/partial_shuffle_sampler.sv
`timescale 1ns / 1ps
// Top level of the partial shuffle sampler.
//
// Draws values 0..upper_bound without replacement (partial shuffle).
// req_bus carries one transaction per item: action start (open a new draw)
// or extract (random_word picks one of the remaining values). rsp_bus
// returns exactly one transaction per request: drawn_value, error, last.
// csr_we/csr_index/csr_wdata write upper_bound (index 0) and
// extraction_count (index 1); write them only while the block is idle.
//
// Pipeline: accept -> multiply top*r -> round and read pool -> resolve and
// write pool -> response register. One transaction per cycle is sustained
// while rsp_bus is ready; the pool store's forwarding register covers
// back-to-back hits on the same entry. Reset clears all control state and
// valid bits; no clearing pass. A start that passes the count check
// clears the pool valid bits when it leaves stage 3. Each stage holds its
// item while the next is full and stalled, so when rsp_bus stalls the
// pipeline fills (up to four items) before req_bus.ready drops.
module partial_shuffle_sampler import psamp_pkg::*; #(
   parameter int POOL_DEPTH  = DEFAULT_POOL_DEPTH,
   parameter int RANDOM_BITS = DEFAULT_RANDOM_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   psamp_req_if.sink             req_bus,
   psamp_rsp_if.source           rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W  = $clog2(POOL_DEPTH);
   localparam int MAX_IDX = POOL_DEPTH - 1;
   localparam int PROD_W  = ADDR_W + RANDOM_BITS;
   localparam int N_W     = PROD_W + 2;
   localparam int Q_W     = ADDR_W + 1;
   localparam int REM_W   = ((RANDOM_BITS + 1 > Q_W + 1) ? RANDOM_BITS + 1 : Q_W + 1) + 1;
   localparam int CMP_W   = ((ADDR_W > COUNT_W) ? ADDR_W : COUNT_W) + 1;

   // RMAX = 2^RANDOM_BITS - 1, and 2*RMAX, 4*RMAX for the rounding fixup
   localparam logic [N_W-1:0]   RMAX_N = {{(N_W - RANDOM_BITS){1'b0}}, {RANDOM_BITS{1'b1}}};
   localparam logic [REM_W-1:0] TWO_M  = REM_W'({{RANDOM_BITS{1'b1}}, 1'b0});
   localparam logic [REM_W-1:0] FOUR_M = REM_W'({{RANDOM_BITS{1'b1}}, 2'b00});

   // configuration
   logic [BOUND_W-1:0] upper_bound_ff;
   logic [COUNT_W-1:0] extraction_count_ff;

   // draw bookkeeping, updated at accept time
   logic               draw_open_ff, draw_open_in;
   logic [ADDR_W-1:0]  top_ff, top_in;
   logic [COUNT_W-1:0] drawn_ff, drawn_in;

   // stage 1: accepted transaction
   logic                   v1_ff, start1_ff, ok1_ff, last1_ff;
   logic [ADDR_W-1:0]      top1_ff;
   logic [RANDOM_BITS-1:0] r1_ff;
   // stage 2: product registered
   logic                   v2_ff, start2_ff, ok2_ff, last2_ff;
   logic [ADDR_W-1:0]      top2_ff;
   logic [PROD_W-1:0]      prod2_ff;
   // stage 3: index known, pool data registered
   logic                   v3_ff, start3_ff, ok3_ff, last3_ff;
   logic [ADDR_W-1:0]      top3_ff, idx3_ff;
   // response register
   logic                   out_v_ff, out_err_ff, out_last_ff;
   logic [DATA_W-1:0]      out_value_ff;

   logic                   c_out, c3, c2, c1;
   logic                   req_fire;
   logic [RANDOM_BITS-1:0] r_in;
   logic [ADDR_W-1:0]      bound_sel;
   logic                   count_ok;
   logic                   can_draw;
   logic                   is_start;
   logic                   ok1_in, last1_in;
   logic [PROD_W-1:0]      prod_in;
   logic [N_W-1:0]         num2;
   logic [Q_W-1:0]         q0, q2;
   logic [REM_W-1:0]       rem2;
   logic [ADDR_W-1:0]      idx2;
   logic [DATA_W-1:0]      idx_value;
   pool_ctl_type           pool_ctl;

   // ---------------------------------------------------------------
   // Flow control: a stage takes a new item when empty or moving on
   // ---------------------------------------------------------------
   assign c_out    = !out_v_ff || rsp_bus.ready;
   assign c3       = !v3_ff || c_out;
   assign c2       = !v2_ff || c3;
   assign c1       = !v1_ff || c2;
   assign req_bus.ready = c1;
   assign req_fire = req_bus.valid && c1;

   // only the low RANDOM_BITS bits of the random word count
   if (RANDOM_BITS <= RANDOM_W) begin : g_r_trim
      assign r_in = req_bus.random_word[RANDOM_BITS-1:0];
   end else begin : g_r_ext
      assign r_in = {{(RANDOM_BITS - RANDOM_W){1'b0}}, req_bus.random_word};
   end

   // ---------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_bound_ff      <= UPPER_BOUND_RESET;
         extraction_count_ff <= EXTRACTION_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_UPPER_BOUND:      upper_bound_ff      <= csr_wdata[BOUND_W-1:0];
            CSR_EXTRACTION_COUNT: extraction_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Accept: decide start/extract outcome and advance the draw state
   // ---------------------------------------------------------------
   always_comb begin
      bound_sel = (int'(upper_bound_ff) > MAX_IDX) ? ADDR_W'(MAX_IDX)
                                                   : ADDR_W'(upper_bound_ff);
      count_ok  = CMP_W'(extraction_count_ff) <= (CMP_W'(bound_sel) + CMP_W'(1));
      can_draw  = draw_open_ff && (drawn_ff < extraction_count_ff);
      is_start  = (req_bus.action == ACT_START);
      ok1_in    = is_start ? count_ok : can_draw;
      last1_in  = !is_start && can_draw &&
                  ((drawn_ff + COUNT_W'(1)) == extraction_count_ff);

      draw_open_in = draw_open_ff;
      top_in       = top_ff;
      drawn_in     = drawn_ff;
      if (req_fire) begin
         if (is_start) begin
            draw_open_in = count_ok;
            if (count_ok) begin
               top_in   = bound_sel;
               drawn_in = '0;
            end
         end else if (can_draw) begin
            // top saturates at zero on the final extraction
            top_in   = (top_ff == '0) ? '0 : top_ff - ADDR_W'(1);
            drawn_in = drawn_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_open_ff <= 1'b0;
         top_ff       <= '0;
         drawn_ff     <= '0;
      end else begin
         draw_open_ff <= draw_open_in;
         top_ff       <= top_in;
         drawn_ff     <= drawn_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1 -> 2: top * r
   // ---------------------------------------------------------------
   assign prod_in = {{RANDOM_BITS{1'b0}}, top1_ff} * {{ADDR_W{1'b0}}, r1_ff};

   // ---------------------------------------------------------------
   // Stage 2: idx = floor((2*top*r + RMAX) / (2*RMAX)), clamped to top.
   // Split at 2^(B+1): N = q0*2M + (lo + 2*q0); the remainder term
   // stays below 6M, so at most two fixups.
   // ---------------------------------------------------------------
   always_comb begin
      num2 = {1'b0, prod2_ff, 1'b0} + RMAX_N;
      q0   = num2[N_W-1:RANDOM_BITS+1];
      rem2 = REM_W'(num2[RANDOM_BITS:0]) + REM_W'({q0, 1'b0});
      q2   = q0 + Q_W'(rem2 >= TWO_M) + Q_W'(rem2 >= FOUR_M);
      idx2 = (q2 > {1'b0, top2_ff}) ? top2_ff : q2[ADDR_W-1:0];
   end

   // ---------------------------------------------------------------
   // Pipeline registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (c1)    v1_ff    <= req_bus.valid;
         if (c2)    v2_ff    <= v1_ff;
         if (c3)    v3_ff    <= v2_ff;
         if (c_out) out_v_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c1) begin
         start1_ff <= is_start;
         ok1_ff    <= ok1_in;
         last1_ff  <= last1_in;
         top1_ff   <= top_ff;
         r1_ff     <= r_in;
      end
      if (c2) begin
         start2_ff <= start1_ff;
         ok2_ff    <= ok1_ff;
         last2_ff  <= last1_ff;
         top2_ff   <= top1_ff;
         prod2_ff  <= prod_in;
      end
      if (c3) begin
         start3_ff <= start2_ff;
         ok3_ff    <= ok2_ff;
         last3_ff  <= last2_ff;
         top3_ff   <= top2_ff;
         idx3_ff   <= idx2;
      end
      if (c_out) begin
         out_value_ff <= (!start3_ff && ok3_ff) ? idx_value : '0;
         out_err_ff   <= !ok3_ff;
         out_last_ff  <= last3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Pool: read as an item moves from stage 2 into stage 3, update when stage 3 retires
   // ---------------------------------------------------------------
   always_comb begin
      pool_ctl.rd_en = c3;
      pool_ctl.clear = v3_ff && c_out && start3_ff && ok3_ff;
      pool_ctl.wr_en = v3_ff && c_out && !start3_ff && ok3_ff;
   end

   psamp_pool #(
      .POOL_DEPTH (POOL_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_pool (
      .clock       (clock),
      .reset       (reset),
      .ctl         (pool_ctl),
      .rd_idx_addr (idx2),
      .rd_top_addr (top2_ff),
      .cur_idx     (idx3_ff),
      .cur_top     (top3_ff),
      .idx_value   (idx_value)
   );

   // ---------------------------------------------------------------
   // Response
   // ---------------------------------------------------------------
   assign rsp_bus.valid       = out_v_ff;
   assign rsp_bus.drawn_value = out_value_ff;
   assign rsp_bus.error       = out_err_ff;
   assign rsp_bus.last        = out_last_ff;

   a_idx_in_pool: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !start3_ff && ok3_ff |-> idx3_ff <= top3_ff)
      else $error("drawn index above pool top");

   a_refused_keeps_top: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_bus.action == ACT_EXTRACT) && !can_draw |=> $stable(top_ff))
      else $error("refused extraction moved the pool top");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.error |-> (rsp_bus.drawn_value == '0) && !rsp_bus.last)
      else $error("error response carries a value or last flag");

endmodule

>>> rtl/psamp_pool.sv
`timescale 1ns / 1ps
// Pool store with per-entry valid bits and write forwarding.
module psamp_pool import psamp_pkg::*; #(
   parameter int POOL_DEPTH = DEFAULT_POOL_DEPTH,
   parameter int ADDR_W     = $clog2(POOL_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  pool_ctl_type      ctl,
   input  logic [ADDR_W-1:0] rd_idx_addr,
   input  logic [ADDR_W-1:0] rd_top_addr,
   input  logic [ADDR_W-1:0] cur_idx,
   input  logic [ADDR_W-1:0] cur_top,
   output logic [DATA_W-1:0] idx_value
);

   logic [DATA_W-1:0]     mem [POOL_DEPTH];
   logic [DATA_W-1:0]     rd_idx_ff;
   logic [DATA_W-1:0]     rd_top_ff;
   logic [POOL_DEPTH-1:0] valid_ff;
   logic                  wb_valid_ff;
   logic [ADDR_W-1:0]     wb_addr_ff;
   logic [DATA_W-1:0]     wb_data_ff;
   logic                  idx_hit;
   logic                  top_hit;
   logic [DATA_W-1:0]     top_value;

   // read-before-write memory; the write from the same edge is forwarded
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_idx_ff <= mem[rd_idx_addr];
         rd_top_ff <= mem[rd_top_addr];
      end
      if (ctl.wr_en) begin
         mem[cur_idx] <= top_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[cur_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         wb_valid_ff <= ctl.wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         wb_addr_ff <= cur_idx;
         wb_data_ff <= top_value;
      end
   end

   assign idx_hit = wb_valid_ff && (wb_addr_ff == cur_idx);
   assign top_hit = wb_valid_ff && (wb_addr_ff == cur_top);

   // unwritten entries hold their own index
   assign idx_value = !valid_ff[cur_idx] ? DATA_W'(cur_idx) :
                      (idx_hit ? wb_data_ff : rd_idx_ff);
   assign top_value = !valid_ff[cur_top] ? DATA_W'(cur_top) :
                      (top_hit ? wb_data_ff : rd_top_ff);

   a_clear_wr_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctl.clear && ctl.wr_en))
      else $error("pool clear and write in the same cycle");

   a_wr_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |=> valid_ff[$past(cur_idx)])
      else $error("written pool entry not marked valid");

   a_fwd_only_valid: assert property (@(posedge clock) disable iff (reset)
      idx_hit |-> valid_ff[cur_idx])
      else $error("forwarded entry has no valid bit");

endmodule
